>>> rtl/rmrob_pkg.sv
// Shared constants and types for the rename map and reorder buffer.
`default_nettype none

package rmrob_pkg;

   localparam int REG_W = 6;
   localparam int TAG_W = 6;
   localparam int GW_W  = 4;

   localparam int ROB_DEPTH_DEF = 64;
   localparam int ARCH_REGS_DEF = 64;

   localparam logic [1:0] KIND_RENAME   = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_RETIRE   = 2'd2;

   localparam logic [GW_W-1:0] GW_RESET = 4'd4;
   localparam logic [GW_W-1:0] GW_MAX   = 4'd8;

   // Map table command from the sequencer: one read port, one set, one clear.
   typedef struct packed {
      logic [REG_W-1:0] rd_reg;
      logic             wr_en;
      logic [REG_W-1:0] wr_reg;
      logic             clr_en;
      logic [REG_W-1:0] clr_reg;
   } map_cmd_type;

endpackage

`default_nettype wire

>>> rtl/rmrob_if.sv
// Channel interfaces: request, response and control register write.
`default_nettype none

interface rmrob_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic                        has_dest;
   logic [rmrob_pkg::REG_W-1:0] dest_reg;
   logic                        has_src1;
   logic [rmrob_pkg::REG_W-1:0] src1_reg;
   logic                        has_src2;
   logic [rmrob_pkg::REG_W-1:0] src2_reg;
   logic [rmrob_pkg::TAG_W-1:0] done_tag;

   modport source (output valid, kind, has_dest, dest_reg, has_src1, src1_reg,
                   has_src2, src2_reg, done_tag, input ready);
   modport sink   (input valid, kind, has_dest, dest_reg, has_src1, src1_reg,
                   has_src2, src2_reg, done_tag, output ready);
endinterface

interface rmrob_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic [rmrob_pkg::TAG_W-1:0] dest_tag;
   logic [rmrob_pkg::TAG_W-1:0] src1_tag;
   logic                        src1_wait;
   logic [rmrob_pkg::TAG_W-1:0] src2_tag;
   logic                        src2_wait;
   logic                        retire_valid;
   logic [rmrob_pkg::TAG_W-1:0] retire_tag;
   logic                        retire_has_dest;
   logic [rmrob_pkg::REG_W-1:0] retire_dest_reg;
   logic                        last;

   modport source (output valid, accepted, dest_tag, src1_tag, src1_wait, src2_tag,
                   src2_wait, retire_valid, retire_tag, retire_has_dest,
                   retire_dest_reg, last, input ready);
   modport sink   (input valid, accepted, dest_tag, src1_tag, src1_wait, src2_tag,
                   src2_wait, retire_valid, retire_tag, retire_has_dest,
                   retire_dest_reg, last, output ready);
endinterface

interface rmrob_csr_if;
   logic                       valid;
   logic                       ready;
   logic [rmrob_pkg::GW_W-1:0] group_width;

   modport source (output valid, group_width, input ready);
   modport sink   (input valid, group_width, output ready);
endinterface

`default_nettype wire

>>> rtl/rmrob_map.sv
// Register rename map: valid bits in flops, producer tags in a memory.
`default_nettype none

module rmrob_map #(
   parameter int ARCH_REGS = rmrob_pkg::ARCH_REGS_DEF,
   parameter int ROB_DEPTH = rmrob_pkg::ROB_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rmrob_pkg::map_cmd_type       cmd,
   input  wire logic [$clog2(ROB_DEPTH)-1:0] wr_tag,
   output logic                              rd_hit,
   output logic [$clog2(ROB_DEPTH)-1:0]      rd_tag
);

   localparam int TW = $clog2(ROB_DEPTH);
   localparam int MW = $clog2(ARCH_REGS);

   logic [ARCH_REGS-1:0] map_valid_ff;
   logic [TW-1:0]        map_tag_ff [ARCH_REGS];
   logic                 rd_hit_ff;
   logic [TW-1:0]        rd_tag_ff;
   logic                 rd_ok;
   logic                 wr_ok;
   logic                 clr_ok;

   // register numbers past the map count as absent
   assign rd_ok  = int'(cmd.rd_reg) < ARCH_REGS;
   assign wr_ok  = cmd.wr_en && (int'(cmd.wr_reg) < ARCH_REGS);
   assign clr_ok = cmd.clr_en && (int'(cmd.clr_reg) < ARCH_REGS);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
      end else begin
         if (clr_ok) begin
            map_valid_ff[MW'(cmd.clr_reg)] <= 1'b0;
         end
         if (wr_ok) begin
            map_valid_ff[MW'(cmd.wr_reg)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         map_tag_ff[MW'(cmd.wr_reg)] <= wr_tag;
      end
      rd_tag_ff <= map_tag_ff[MW'(cmd.rd_reg)];
      rd_hit_ff <= rd_ok && map_valid_ff[MW'(cmd.rd_reg)];
   end

   assign rd_hit = rd_hit_ff;
   assign rd_tag = rd_tag_ff;

endmodule

`default_nettype wire

>>> rtl/rename_map_and_reorder_buffer.sv
// Top level: reorder buffer with register rename map and its sequencer.
//
//   channel  dir  transfer when          payload
//   req_if   in   valid & ready         kind, has_dest/dest_reg, has_srcN/srcN_reg, done_tag
//   rsp_if   out  valid & ready         accepted, tags, waits, retire fields, last
//   csr_if   in   valid & ready (ready  group_width
//                 is high out of reset)
//
// A rename answers unaccepted when stalled for space; a retire tick retires ready head
// entries up to the group width, one per response, or gives one empty result.
// Map table and entry destination store have one registered read port each.
// Synchronous reset clears pointers, valid/ready bits and map valid bits; no clearing
// pass. req_if.ready is high only in idle, out of reset.
`default_nettype none

module rename_map_and_reorder_buffer #(
   parameter int ROB_DEPTH = rmrob_pkg::ROB_DEPTH_DEF,
   parameter int ARCH_REGS = rmrob_pkg::ARCH_REGS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   rmrob_req_if.sink   req_if,
   rmrob_rsp_if.source rsp_if,
   rmrob_csr_if.sink   csr_if
);

   localparam int TW = $clog2(ROB_DEPTH);
   localparam int OW = $clog2(ROB_DEPTH + 1);
   localparam int RW = rmrob_pkg::REG_W;
   localparam int GW = rmrob_pkg::GW_W;
   localparam int XW = rmrob_pkg::TAG_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMP,
      ST_REN_RD1,
      ST_REN_RD2,
      ST_REN_WR,
      ST_RET_CHK,
      ST_RET_DST,
      ST_RET_MAP,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [GW-1:0]        gw_ff;
   logic [TW-1:0]        head_ff;
   logic [TW-1:0]        tail_ff;
   logic [OW-1:0]        occ_ff;
   logic [GW-1:0]        n_ff;            // entries retired in this tick
   logic [ROB_DEPTH-1:0] entry_valid_ff;
   logic [ROB_DEPTH-1:0] entry_ready_ff;
   logic [RW:0]          entry_dest_ff [ROB_DEPTH];
   logic [RW:0]          dest_rd_ff;      // {has_dest, reg} at head

   // latched request
   logic          has_dest_ff;
   logic [RW-1:0] dest_reg_ff;
   logic          has_src1_ff;
   logic [RW-1:0] src1_reg_ff;
   logic          has_src2_ff;
   logic [RW-1:0] src2_reg_ff;
   logic [XW-1:0] done_tag_ff;

   logic          s1_wait_ff;
   logic [XW-1:0] s1_tag_ff;

   // response register
   logic          rsp_accepted_ff;
   logic [XW-1:0] rsp_dest_tag_ff;
   logic [XW-1:0] rsp_src1_tag_ff;
   logic          rsp_src1_wait_ff;
   logic [XW-1:0] rsp_src2_tag_ff;
   logic          rsp_src2_wait_ff;
   logic          rsp_retire_valid_ff;
   logic [XW-1:0] rsp_retire_tag_ff;
   logic          rsp_retire_has_dest_ff;
   logic [RW-1:0] rsp_retire_dest_reg_ff;
   logic          rsp_last_ff;

   rmrob_pkg::map_cmd_type map_cmd;
   logic                   map_rd_hit;
   logic [TW-1:0]          map_rd_tag;

   logic [GW-1:0] eff_w;
   logic          ren_stall;
   logic [TW-1:0] head_nx;
   logic [TW-1:0] tail_nx;
   logic          head_go;
   logic          next_go;
   logic [GW-1:0] n_inc;
   logic          src_wait;       // source lookup result in the current cycle
   logic [XW-1:0] src_tag;
   logic          done_ok;
   logic [TW-1:0] done_idx;

   // width register clamped to 1..8
   always_comb begin
      if (gw_ff == '0) begin
         eff_w = GW'(1);
      end else if (gw_ff > rmrob_pkg::GW_MAX) begin
         eff_w = rmrob_pkg::GW_MAX;
      end else begin
         eff_w = gw_ff;
      end
   end

   assign ren_stall = ((OW+1)'(occ_ff) + (OW+1)'(eff_w)) > (OW+1)'(ROB_DEPTH);

   assign head_nx = (head_ff == TW'(ROB_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_nx = (tail_ff == TW'(ROB_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign n_inc   = n_ff + 1'b1;

   assign head_go = (n_ff < eff_w) && entry_valid_ff[head_ff] && entry_ready_ff[head_ff];
   // lookahead: decides whether the entry retiring now is the last one
   assign next_go = (n_inc < eff_w) && entry_valid_ff[head_nx] && entry_ready_ff[head_nx];

   // map read came back this cycle; a valid map entry always names a live entry
   always_comb begin
      if (state_ff == ST_REN_RD2) begin
         src_wait = has_src1_ff && map_rd_hit && !entry_ready_ff[map_rd_tag];
      end else begin
         src_wait = has_src2_ff && map_rd_hit && !entry_ready_ff[map_rd_tag];
      end
      src_tag = src_wait ? XW'(map_rd_tag) : '0;
   end

   assign done_ok  = int'(done_tag_ff) < ROB_DEPTH;
   assign done_idx = TW'(done_tag_ff);

   // map table port steering
   always_comb begin
      case (state_ff)
         ST_REN_RD1: map_cmd.rd_reg = src1_reg_ff;
         ST_REN_RD2: map_cmd.rd_reg = src2_reg_ff;
         default:    map_cmd.rd_reg = dest_rd_ff[RW-1:0];
      endcase
      map_cmd.wr_en   = (state_ff == ST_REN_WR) && has_dest_ff;
      map_cmd.wr_reg  = dest_reg_ff;
      // release the map entry only if it still names the retiring tag
      map_cmd.clr_en  = (state_ff == ST_RET_MAP) && dest_rd_ff[RW] && map_rd_hit &&
                        (map_rd_tag == head_ff);
      map_cmd.clr_reg = dest_rd_ff[RW-1:0];
   end

   rmrob_map #(
      .ARCH_REGS (ARCH_REGS),
      .ROB_DEPTH (ROB_DEPTH)
   ) u_map (
      .clock  (clock),
      .reset  (reset),
      .cmd    (map_cmd),
      .wr_tag (tail_ff),
      .rd_hit (map_rd_hit),
      .rd_tag (map_rd_tag)
   );

   // entry destination store, read continuously at the head
   always_ff @(posedge clock) begin
      if (state_ff == ST_REN_WR) begin
         entry_dest_ff[tail_ff] <= {has_dest_ff, dest_reg_ff};
      end
      dest_rd_ff <= entry_dest_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gw_ff          <= rmrob_pkg::GW_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         occ_ff         <= '0;
         n_ff           <= '0;
         entry_valid_ff <= '0;
         entry_ready_ff <= '0;
      end else begin
         if (csr_if.valid) begin
            gw_ff <= csr_if.group_width;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  has_dest_ff <= req_if.has_dest;
                  dest_reg_ff <= req_if.dest_reg;
                  has_src1_ff <= req_if.has_src1;
                  src1_reg_ff <= req_if.src1_reg;
                  has_src2_ff <= req_if.has_src2;
                  src2_reg_ff <= req_if.src2_reg;
                  done_tag_ff <= req_if.done_tag;
                  n_ff        <= '0;
                  case (req_if.kind)
                     rmrob_pkg::KIND_RENAME:   state_ff <= ST_REN_RD1;
                     rmrob_pkg::KIND_COMPLETE: state_ff <= ST_CMP;
                     rmrob_pkg::KIND_RETIRE:   state_ff <= ST_RET_CHK;
                     default:                  state_ff <= ST_IDLE;
                  endcase
               end
            end

            ST_CMP: begin
               if (done_ok && entry_valid_ff[done_idx]) begin
                  entry_ready_ff[done_idx] <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end

            ST_REN_RD1: begin
               if (ren_stall) begin
                  rsp_accepted_ff        <= 1'b0;
                  rsp_dest_tag_ff        <= '0;
                  rsp_src1_tag_ff        <= '0;
                  rsp_src1_wait_ff       <= 1'b0;
                  rsp_src2_tag_ff        <= '0;
                  rsp_src2_wait_ff       <= 1'b0;
                  rsp_retire_valid_ff    <= 1'b0;
                  rsp_retire_tag_ff      <= '0;
                  rsp_retire_has_dest_ff <= 1'b0;
                  rsp_retire_dest_reg_ff <= '0;
                  rsp_last_ff            <= 1'b1;
                  state_ff               <= ST_OUT;
               end else begin
                  state_ff <= ST_REN_RD2;
               end
            end

            ST_REN_RD2: begin
               s1_wait_ff <= src_wait;
               s1_tag_ff  <= src_tag;
               state_ff   <= ST_REN_WR;
            end

            ST_REN_WR: begin
               entry_valid_ff[tail_ff] <= 1'b1;
               entry_ready_ff[tail_ff] <= 1'b0;
               tail_ff                 <= tail_nx;
               occ_ff                  <= occ_ff + 1'b1;
               rsp_accepted_ff         <= 1'b1;
               rsp_dest_tag_ff         <= XW'(tail_ff);
               rsp_src1_tag_ff         <= s1_tag_ff;
               rsp_src1_wait_ff        <= s1_wait_ff;
               rsp_src2_tag_ff         <= src_tag;
               rsp_src2_wait_ff        <= src_wait;
               rsp_retire_valid_ff     <= 1'b0;
               rsp_retire_tag_ff       <= '0;
               rsp_retire_has_dest_ff  <= 1'b0;
               rsp_retire_dest_reg_ff  <= '0;
               rsp_last_ff             <= 1'b1;
               state_ff                <= ST_OUT;
            end

            ST_RET_CHK: begin
               if (head_go) begin
                  state_ff <= ST_RET_DST;
               end else begin
                  // nothing retires: one empty result
                  rsp_accepted_ff        <= 1'b0;
                  rsp_dest_tag_ff        <= '0;
                  rsp_src1_tag_ff        <= '0;
                  rsp_src1_wait_ff       <= 1'b0;
                  rsp_src2_tag_ff        <= '0;
                  rsp_src2_wait_ff       <= 1'b0;
                  rsp_retire_valid_ff    <= 1'b0;
                  rsp_retire_tag_ff      <= '0;
                  rsp_retire_has_dest_ff <= 1'b0;
                  rsp_retire_dest_reg_ff <= '0;
                  rsp_last_ff            <= 1'b1;
                  state_ff               <= ST_OUT;
               end
            end

            ST_RET_DST: begin
               state_ff <= ST_RET_MAP;
            end

            ST_RET_MAP: begin
               entry_valid_ff[head_ff] <= 1'b0;
               entry_ready_ff[head_ff] <= 1'b0;
               head_ff                 <= head_nx;
               occ_ff                  <= occ_ff - 1'b1;
               n_ff                    <= n_inc;
               rsp_accepted_ff         <= 1'b0;
               rsp_dest_tag_ff         <= '0;
               rsp_src1_tag_ff         <= '0;
               rsp_src1_wait_ff        <= 1'b0;
               rsp_src2_tag_ff         <= '0;
               rsp_src2_wait_ff        <= 1'b0;
               rsp_retire_valid_ff     <= 1'b1;
               rsp_retire_tag_ff       <= XW'(head_ff);
               rsp_retire_has_dest_ff  <= dest_rd_ff[RW];
               rsp_retire_dest_reg_ff  <= dest_rd_ff[RW-1:0];
               rsp_last_ff             <= !next_go;
               state_ff                <= ST_OUT;
            end

            ST_OUT: begin
               if (rsp_if.ready) begin
                  state_ff <= rsp_last_ff ? ST_IDLE : ST_RET_CHK;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_if.ready = !reset;

   assign rsp_if.valid           = (state_ff == ST_OUT);
   assign rsp_if.accepted        = rsp_accepted_ff;
   assign rsp_if.dest_tag        = rsp_dest_tag_ff;
   assign rsp_if.src1_tag        = rsp_src1_tag_ff;
   assign rsp_if.src1_wait       = rsp_src1_wait_ff;
   assign rsp_if.src2_tag        = rsp_src2_tag_ff;
   assign rsp_if.src2_wait       = rsp_src2_wait_ff;
   assign rsp_if.retire_valid    = rsp_retire_valid_ff;
   assign rsp_if.retire_tag      = rsp_retire_tag_ff;
   assign rsp_if.retire_has_dest = rsp_retire_has_dest_ff;
   assign rsp_if.retire_dest_reg = rsp_retire_dest_reg_ff;
   assign rsp_if.last            = rsp_last_ff;

endmodule

`default_nettype wire
